### design/rrps_pkg.sv
// Shared constants and controller/datapath interface types for the round-robin pair schedule.
`timescale 1ns / 1ps

package rrps_pkg;

   // Node numbering
   localparam int MAX_NODES    = 16;
   localparam int NODE_W       = 4;   // width of a node number
   localparam int COUNT_W      = 5;   // width of a node count, holds MAX_NODES itself
   localparam int PAIR_W       = 3;   // width of a pair position within a round
   localparam int HALF_W       = 4;   // width of the pair count of a round

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // take a request, set up the first pair or the bad-round result
      logic seed;      // start the transmitter walk of the next pair
      logic step_fwd;  // try one candidate of the transmitter walk
      logic step_bwd;  // try one candidate of the receiver walk
   } rrps_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic found;     // the current walk has chosen its node
      logic last;      // the held response closes the round
   } rrps_stat_type;

endpackage

### design/rrps_ctrl.sv
// Controller state machine: sequences request intake, node walks and response hand-off.
`timescale 1ns / 1ps

module rrps_ctrl
   import rrps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rrps_cmd_type  cmd,
   input  rrps_stat_type stat
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_OUT     = 2'd1;
   localparam logic [1:0] ST_WALK_TX = 2'd2;
   localparam logic [1:0] ST_WALK_RX = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (stat.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.seed = 1'b1;
                  state_in = ST_WALK_TX;
               end
            end
         end
         ST_WALK_TX: begin
            cmd.step_fwd = 1'b1;
            if (stat.found) begin
               state_in = ST_WALK_RX;
            end
         end
         ST_WALK_RX: begin
            cmd.step_bwd = 1'b1;
            if (stat.found) begin
               state_in = ST_OUT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/rrps_datapath.sv
// Datapath: node count register, used-node marks, walk cursor and response register.
`timescale 1ns / 1ps

module rrps_datapath
   import rrps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [COUNT_W-1:0]   csr_node_count,
   input  logic [NODE_W-1:0]    req_round_index,
   input  rrps_cmd_type         cmd,
   output rrps_stat_type        stat,
   output logic [NODE_W-1:0]    rsp_tx_node,
   output logic [NODE_W-1:0]    rsp_rx_node,
   output logic [PAIR_W-1:0]    rsp_pair_number,
   output logic                 rsp_last_pair,
   output logic                 rsp_bad_round
);

   logic [COUNT_W-1:0]   node_count_ff, node_count_in;
   logic [COUNT_W-1:0]   n_ff, n_in;
   logic [NODE_W-1:0]    tx_ff, tx_in;
   logic [NODE_W-1:0]    rx_ff, rx_in;
   logic [NODE_W-1:0]    cursor_ff, cursor_in;
   logic [COUNT_W-1:0]   steps_ff, steps_in;
   logic [MAX_NODES-1:0] marks_ff, marks_in;
   logic [NODE_W-1:0]    out_tx_ff, out_tx_in;
   logic [NODE_W-1:0]    out_rx_ff, out_rx_in;
   logic [PAIR_W-1:0]    out_pair_ff, out_pair_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_bad_ff, out_bad_in;

   logic [COUNT_W-1:0]   cnt_sat;
   logic [COUNT_W-1:0]   n_cur;
   logic                 bad_req;
   logic [NODE_W-1:0]    start_node;
   logic [COUNT_W-1:0]   fwd_sum;
   logic [NODE_W-1:0]    fwd_cand;
   logic [NODE_W-1:0]    bwd_cand;
   logic [NODE_W-1:0]    cand;
   logic                 found;
   logic [PAIR_W-1:0]    next_pair;
   logic [HALF_W-1:0]    next_pair_plus1;

   // Saturate and round the configured count up to even
   assign cnt_sat    = (node_count_ff > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                             : node_count_ff;
   assign n_cur      = cnt_sat + {{(COUNT_W-1){1'b0}}, cnt_sat[0]};
   assign bad_req    = (n_cur < COUNT_W'(2)) ||
                       ({1'b0, req_round_index} >= (n_cur - COUNT_W'(1)));
   assign start_node = req_round_index + NODE_W'(1);

   // One candidate of the walk: forward wraps to 0, backward wraps to n-1
   assign fwd_sum  = {1'b0, cursor_ff} + COUNT_W'(1);
   assign fwd_cand = (fwd_sum >= n_ff) ? '0 : fwd_sum[NODE_W-1:0];
   assign bwd_cand = (cursor_ff == '0) ? NODE_W'(n_ff - COUNT_W'(1))
                                       : cursor_ff - NODE_W'(1);
   assign cand     = cmd.step_bwd ? bwd_cand : fwd_cand;
   // Take a free node, or the last candidate once n have been tried
   assign found    = !marks_ff[cand] || ((steps_ff + COUNT_W'(1)) == n_ff);

   assign next_pair       = out_pair_ff + PAIR_W'(1);
   assign next_pair_plus1 = {1'b0, next_pair} + HALF_W'(1);

   assign stat.found = found;
   assign stat.last  = out_last_ff;

   assign rsp_tx_node     = out_tx_ff;
   assign rsp_rx_node     = out_rx_ff;
   assign rsp_pair_number = out_pair_ff;
   assign rsp_last_pair   = out_last_ff;
   assign rsp_bad_round   = out_bad_ff;

   // Next values of the datapath registers
   always_comb begin
      node_count_in = node_count_ff;
      n_in          = n_ff;
      tx_in         = tx_ff;
      rx_in         = rx_ff;
      cursor_in     = cursor_ff;
      steps_in      = steps_ff;
      marks_in      = marks_ff;
      out_tx_in     = out_tx_ff;
      out_rx_in     = out_rx_ff;
      out_pair_in   = out_pair_ff;
      out_last_in   = out_last_ff;
      out_bad_in    = out_bad_ff;

      if (csr_valid) begin
         node_count_in = csr_node_count;
      end

      // Set up a new request: first pair or a flagged result
      if (cmd.load) begin
         n_in        = n_cur;
         out_pair_in = '0;
         if (bad_req) begin
            out_tx_in   = '0;
            out_rx_in   = '0;
            out_last_in = 1'b1;
            out_bad_in  = 1'b1;
         end else begin
            marks_in             = '0;
            marks_in[0]          = 1'b1;
            marks_in[start_node] = 1'b1;
            tx_in                = start_node;
            rx_in                = start_node;
            out_tx_in            = '0;
            out_rx_in            = start_node;
            out_last_in          = (n_cur[COUNT_W-1:1] == HALF_W'(1));
            out_bad_in           = 1'b0;
         end
      end

      // Start the transmitter walk from the last transmitter
      if (cmd.seed) begin
         cursor_in = tx_ff;
         steps_in  = '0;
      end

      // Advance the transmitter walk; on a hit seed the receiver walk
      if (cmd.step_fwd) begin
         if (found) begin
            marks_in[cand] = 1'b1;
            tx_in          = cand;
            cursor_in      = rx_ff;
            steps_in       = '0;
         end else begin
            cursor_in = cand;
            steps_in  = steps_ff + COUNT_W'(1);
         end
      end

      // Advance the receiver walk; on a hit load the next pair
      if (cmd.step_bwd) begin
         if (found) begin
            marks_in[cand] = 1'b1;
            rx_in          = cand;
            out_tx_in      = tx_ff;
            out_rx_in      = cand;
            out_pair_in    = next_pair;
            out_last_in    = (next_pair_plus1 == n_ff[COUNT_W-1:1]);
            out_bad_in     = 1'b0;
         end else begin
            cursor_in = cand;
            steps_in  = steps_ff + COUNT_W'(1);
         end
      end
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_W'(MAX_NODES);
         marks_ff      <= '0;
      end else begin
         node_count_ff <= node_count_in;
         marks_ff      <= marks_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      tx_ff       <= tx_in;
      rx_ff       <= rx_in;
      cursor_ff   <= cursor_in;
      steps_ff    <= steps_in;
      out_tx_ff   <= out_tx_in;
      out_rx_ff   <= out_rx_in;
      out_pair_ff <= out_pair_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
   end

endmodule

### design/round_robin_pair_schedule_top.sv
// Top level of the round-robin pair schedule: controller and datapath.
//
// Usage: write the node count (1 to 16, odd counts rounded up to even, n)
// on the csr_ channel while the block is idle; csr_ready is always high.
// Each request on the req_ channel carries a round index and produces the
// n/2 transmitter/receiver pairs of that round on the rsp_ channel, in
// order, with last_pair set on the final one. A round index of n-1 or more
// gives one response with bad_round set and both nodes zero.
// The first pair is valid in the cycle after the request is taken.
// Each further pair is found by a forward walk and then a backward
// walk, each walk trying at most n nodes, before its hand-off. The
// walk unit tests one mark per cycle; one request is handled at a time.
// Reset restores a node count of 16 and drops any request in progress.
// When the receiver stalls the response register holds its pair and the
// walk waits; no new request is taken until the round has been delivered.
`timescale 1ns / 1ps

module round_robin_pair_schedule_top
   import rrps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [COUNT_W-1:0]  csr_node_count,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [NODE_W-1:0]   req_round_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [NODE_W-1:0]   rsp_tx_node,
   output logic [NODE_W-1:0]   rsp_rx_node,
   output logic [PAIR_W-1:0]   rsp_pair_number,
   output logic                rsp_last_pair,
   output logic                rsp_bad_round
);

   rrps_cmd_type  cmd;
   rrps_stat_type stat;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   rrps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rrps_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_node_count  (csr_node_count),
      .req_round_index (req_round_index),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_tx_node     (rsp_tx_node),
      .rsp_rx_node     (rsp_rx_node),
      .rsp_pair_number (rsp_pair_number),
      .rsp_last_pair   (rsp_last_pair),
      .rsp_bad_round   (rsp_bad_round)
   );

endmodule
